// ===== rtl/mlle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlle_pkg
// Shared constants, register codes and control types of the multi-lane LED
// chain bit encoder.
// ----------------------------------------------------------------------------
package mlle_pkg;

  localparam int MAX_LEDS      = 256;
  localparam int LANES         = 8;
  localparam int SLOTS_PER_LED = 24;
  localparam int LED_LIMIT     = 2730;
  localparam int LED_CAP       = (MAX_LEDS < LED_LIMIT) ? MAX_LEDS : LED_LIMIT;
  localparam int LED_W         = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int SLOT_W        = 5;
  localparam int WORD_W        = 32;

  localparam logic [7:0] LANE_MASK = 8'((1 << LANES) - 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TICKS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH_TICKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH_TICKS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BITS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LANE_ENABLE     = 3'd5;

  localparam logic [7:0]  RST_PERIOD_TICKS    = 8'd105;
  localparam logic [7:0]  RST_ZERO_HIGH_TICKS = 8'd33;
  localparam logic [7:0]  RST_ONE_HIGH_TICKS  = 8'd68;
  localparam logic [8:0]  RST_LED_COUNT       = 9'd1;
  localparam logic [15:0] RST_FRAME_BITS      = 16'd40000;
  localparam logic [7:0]  RST_LANE_ENABLE     = 8'd1;

  typedef struct packed {
    logic [7:0]  period_ticks;
    logic [7:0]  zero_high_ticks;
    logic [7:0]  one_high_ticks;
    logic [8:0]  led_count;
    logic [15:0] frame_bits;
    logic [7:0]  lane_enable;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic clr;   // clearing pass: zero one store row
    logic acc;   // item accepted this cycle
    logic tick;  // accepted item is a timer tick
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
  } sts_t;

endpackage

// ===== rtl/mlle_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlle_ctrl
// Controller: runs the store clearing pass after reset, then handles the
// item handshake and the output valid flag.
// ----------------------------------------------------------------------------
module mlle_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_action,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  mlle_pkg::sts_t sts,
  output mlle_pkg::cmd_t cmd
);

  typedef enum logic {ST_CLEAR, ST_RUN} state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   accept;

  assign in_ready  = (state_r == ST_RUN) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.clr  = (state_r == ST_CLEAR);
    cmd.acc  = accept;
    cmd.tick = accept && in_action;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_CLEAR: begin
          if (sts.clr_last) state_r <= ST_RUN;
        end
        ST_RUN: begin
          state_r <= ST_RUN;
        end
        default: state_r <= ST_CLEAR;
      endcase
      // hold the result until taken, refill on each accepted item
      if (accept) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR && sts.clr_last) |=> (state_r == ST_RUN))
    else $error("clearing pass did not hand over to run");

endmodule

// ===== rtl/mlle_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlle_datapath
// Slot store, waveform phase and bit period counters, lane levels and the
// result register.
// ----------------------------------------------------------------------------
module mlle_datapath (
  input  logic           clk,
  input  logic           rst_n,
  input  mlle_pkg::cfg_t cfg,
  input  mlle_pkg::cmd_t cmd,
  output mlle_pkg::sts_t sts,
  input  logic [7:0]     in_led_index,
  input  logic [7:0]     in_lane_select,
  input  logic [7:0]     in_green,
  input  logic [7:0]     in_red,
  input  logic [7:0]     in_blue,
  output logic [7:0]     out_lines,
  output logic           out_transmitting,
  output logic [15:0]    out_frame_position
);

  // one row per LED: lane mask over green, red, blue bits
  logic [mlle_pkg::WORD_W-1:0] mem_r [mlle_pkg::MAX_LEDS];
  logic [mlle_pkg::WORD_W-1:0] rd_data_r;

  logic [mlle_pkg::LED_W-1:0]  clr_addr_r;
  logic [7:0]                  phase_r, phase_nxt;
  logic [15:0]                 bit_r, bit_nxt;
  logic [mlle_pkg::LED_W-1:0]  led_idx_r, led_idx_nxt;
  logic [mlle_pkg::SLOT_W-1:0] slot_idx_r, slot_idx_nxt;
  logic [7:0]                  lines_r, lines_nxt;
  logic [7:0]                  out_lines_r;
  logic                        out_tx_r;
  logic [15:0]                 out_pos_r;

  logic [8:0]                  led_n;
  logic [15:0]                 dbits;
  logic [15:0]                 flen;
  logic                        tx;
  logic [23:0]                 colors;
  logic [7:0]                  slot_val;
  logic                        in_range;
  logic                        we;
  logic [mlle_pkg::LED_W-1:0]  wa;
  logic [mlle_pkg::WORD_W-1:0] wd;

  always_comb begin
    if (32'(cfg.led_count) > 32'(mlle_pkg::LED_CAP)) led_n = 9'(mlle_pkg::LED_CAP);
    else led_n = cfg.led_count;
    dbits = 16'(32'(led_n) * mlle_pkg::SLOTS_PER_LED);
    flen  = (cfg.frame_bits > dbits) ? cfg.frame_bits : dbits;
    tx    = bit_r < dbits;
  end

  // slot 0 is the green MSB
  assign colors   = rd_data_r[23:0];
  assign slot_val = colors[5'(mlle_pkg::SLOTS_PER_LED - 1) - slot_idx_r] ? 8'h00
                                                                       : rd_data_r[31:24];

  always_comb begin
    lines_nxt    = lines_r;
    phase_nxt    = phase_r;
    bit_nxt      = bit_r;
    led_idx_nxt  = led_idx_r;
    slot_idx_nxt = slot_idx_r;
    if (cmd.tick) begin
      if (tx) begin
        if (phase_r == 8'd0) lines_nxt = cfg.lane_enable & mlle_pkg::LANE_MASK;
        if (phase_r == cfg.zero_high_ticks) lines_nxt = lines_nxt & ~slot_val;
        if (phase_r == cfg.one_high_ticks) lines_nxt = 8'h00;
        lines_nxt = lines_nxt & mlle_pkg::LANE_MASK;
      end else begin
        lines_nxt = 8'h00;
      end
      if ({1'b0, phase_r} + 9'd1 >= {1'b0, cfg.period_ticks}) begin
        phase_nxt = 8'd0;
        if ({1'b0, bit_r} + 17'd1 >= {1'b0, flen}) begin
          bit_nxt      = 16'd0;
          led_idx_nxt  = '0;
          slot_idx_nxt = '0;
        end else begin
          bit_nxt = bit_r + 16'd1;
          if (slot_idx_r == 5'(mlle_pkg::SLOTS_PER_LED - 1)) begin
            slot_idx_nxt = '0;
            led_idx_nxt  = led_idx_r + 1'b1;
          end else begin
            slot_idx_nxt = slot_idx_r + 1'b1;
          end
        end
      end else begin
        phase_nxt = phase_r + 8'd1;
      end
    end
  end

  // store write port: clearing pass or pixel write
  assign in_range = 32'(in_led_index) < 32'(mlle_pkg::MAX_LEDS);
  assign we = cmd.clr || (cmd.acc && !cmd.tick && in_range);
  assign wa = cmd.clr ? clr_addr_r : mlle_pkg::LED_W'(in_led_index);
  assign wd = cmd.clr ? '0 : {in_lane_select, in_green, in_red, in_blue};

  // read the row of the next bit period; forward a same-cycle write
  always_ff @(posedge clk) begin
    if (we) mem_r[wa] <= wd;
    rd_data_r <= (we && wa == led_idx_nxt) ? wd : mem_r[led_idx_nxt];
  end

  assign sts.clr_last = (clr_addr_r == mlle_pkg::LED_W'(mlle_pkg::MAX_LEDS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      phase_r    <= '0;
      bit_r      <= '0;
      led_idx_r  <= '0;
      slot_idx_r <= '0;
      lines_r    <= '0;
    end else begin
      if (cmd.clr) clr_addr_r <= clr_addr_r + 1'b1;
      phase_r    <= phase_nxt;
      bit_r      <= bit_nxt;
      led_idx_r  <= led_idx_nxt;
      slot_idx_r <= slot_idx_nxt;
      lines_r    <= lines_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      out_lines_r <= lines_nxt;
      out_tx_r    <= tx;
      out_pos_r   <= bit_r;
    end
  end

  assign out_lines          = out_lines_r;
  assign out_transmitting   = out_tx_r;
  assign out_frame_position = out_pos_r;

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_idx_r <= 5'(mlle_pkg::SLOTS_PER_LED - 1))
    else $error("slot counter out of range");

  a_write_holds_wave: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.acc && !cmd.tick) |=> ($stable(bit_r) && $stable(phase_r) && $stable(lines_r)))
    else $error("pixel write moved the waveform");

  a_index_tracks_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (bit_r < dbits) |->
      (16'(32'(led_idx_r) * mlle_pkg::SLOTS_PER_LED + 32'(slot_idx_r)) == bit_r))
    else $error("store row and slot do not match the bit period");

endmodule

// ===== rtl/multi_lane_led_chain_bit_encoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_lane_led_chain_bit_encoder_unit
// Parallel one-wire LED chain encoder: pixel store, bit waveform timing and
// configuration registers.
// ----------------------------------------------------------------------------
// An accepted item's result is registered in the output register the cycle after acceptance.
// Throughput: one item per cycle while out_ready is high; a pixel write stores
//   a whole LED row at once through the single store write port.
// Reset: control state and registers return to defaults; a clearing pass then
//   zeroes all MAX_LEDS (256) store rows, with in_ready low throughout.
module multi_lane_led_chain_bit_encoder_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_action,
  input  logic [7:0]                      in_led_index,
  input  logic [7:0]                      in_lane_select,
  input  logic [7:0]                      in_green,
  input  logic [7:0]                      in_red,
  input  logic [7:0]                      in_blue,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_lines,
  output logic                            out_transmitting,
  output logic [15:0]                     out_frame_position,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mlle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mlle_pkg::CFG_DATA_W-1:0] cfg_data
);

  mlle_pkg::cfg_t cfg_r;
  mlle_pkg::cmd_t cmd;
  mlle_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period_ticks    <= mlle_pkg::RST_PERIOD_TICKS;
      cfg_r.zero_high_ticks <= mlle_pkg::RST_ZERO_HIGH_TICKS;
      cfg_r.one_high_ticks  <= mlle_pkg::RST_ONE_HIGH_TICKS;
      cfg_r.led_count       <= mlle_pkg::RST_LED_COUNT;
      cfg_r.frame_bits      <= mlle_pkg::RST_FRAME_BITS;
      cfg_r.lane_enable     <= mlle_pkg::RST_LANE_ENABLE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mlle_pkg::REG_PERIOD_TICKS:    cfg_r.period_ticks    <= cfg_data[7:0];
        mlle_pkg::REG_ZERO_HIGH_TICKS: cfg_r.zero_high_ticks <= cfg_data[7:0];
        mlle_pkg::REG_ONE_HIGH_TICKS:  cfg_r.one_high_ticks  <= cfg_data[7:0];
        mlle_pkg::REG_LED_COUNT:       cfg_r.led_count       <= cfg_data[8:0];
        mlle_pkg::REG_FRAME_BITS:      cfg_r.frame_bits      <= cfg_data[15:0];
        mlle_pkg::REG_LANE_ENABLE:     cfg_r.lane_enable     <= cfg_data[7:0];
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  mlle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mlle_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .cmd                (cmd),
    .sts                (sts),
    .in_led_index       (in_led_index),
    .in_lane_select     (in_lane_select),
    .in_green           (in_green),
    .in_red             (in_red),
    .in_blue            (in_blue),
    .out_lines          (out_lines),
    .out_transmitting   (out_transmitting),
    .out_frame_position (out_frame_position)
  );

endmodule

// ===== sim/lane_waveform_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lane_waveform_checker
// Watches the item, result and register channels of the LED chain encoder.
// It keeps its own copy of the pixel slots, the bit waveform and the
// registers, predicts the result of every accepted item and compares each
// accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
package lane_tb_pkg;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

endpackage

module lane_waveform_checker
  import mlle_pkg::*;
  import lane_tb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  in_action,
  input  logic [7:0]            in_led_index,
  input  logic [7:0]            in_lane_select,
  input  logic [7:0]            in_green,
  input  logic [7:0]            in_red,
  input  logic [7:0]            in_blue,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [7:0]            out_lines,
  input  logic                  out_transmitting,
  input  logic [15:0]           out_frame_position,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    outstanding
);

  typedef struct packed {
    logic [7:0]  lines;
    logic        transmitting;
    logic [15:0] frame_position;
  } lane_result_t;

  logic [7:0]  slot_mask [0:MAX_LEDS*SLOTS_PER_LED-1];
  logic [7:0]  phase;
  logic [15:0] bit_pos;
  logic [7:0]  levels;

  logic [7:0]  period_r;
  logic [7:0]  zero_at_r;
  logic [7:0]  one_at_r;
  logic [8:0]  leds_r;
  logic [15:0] frame_r;
  logic [7:0]  enable_r;

  lane_result_t expected_results [$];
  int           fail_count = 0;
  int           queued_n = 0;

  assign errors      = fail_count;
  assign outstanding = queued_n;

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic int unsigned data_len();
    int unsigned n;
    n = leds_r;
    if (n > MAX_LEDS) n = MAX_LEDS;
    if (n > LED_LIMIT) n = LED_LIMIT;
    return n * SLOTS_PER_LED;
  endfunction

  task automatic clear_model();
    foreach (slot_mask[i]) slot_mask[i] = 8'h00;
    phase     = '0;
    bit_pos   = '0;
    levels    = '0;
    period_r  = RST_PERIOD_TICKS;
    zero_at_r = RST_ZERO_HIGH_TICKS;
    one_at_r  = RST_ONE_HIGH_TICKS;
    leds_r    = RST_LED_COUNT;
    frame_r   = RST_FRAME_BITS;
    enable_r  = RST_LANE_ENABLE;
  endtask

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_PERIOD_TICKS:    period_r  = data[7:0];
      REG_ZERO_HIGH_TICKS: zero_at_r = data[7:0];
      REG_ONE_HIGH_TICKS:  one_at_r  = data[7:0];
      REG_LED_COUNT:       leds_r    = data[8:0];
      REG_FRAME_BITS:      frame_r   = data[15:0];
      REG_LANE_ENABLE:     enable_r  = data[7:0];
      default: ;
    endcase
  endtask

  // a zero colour bit marks the lanes of the pixel, a one bit marks none
  task automatic store_colour(input int unsigned base, input logic [7:0] colour,
                              input logic [7:0] lanes);
    for (int k = 0; k < 8; k++) begin
      slot_mask[base + k] = colour[7 - k] ? 8'h00 : lanes;
    end
  endtask

  task automatic step_item(input logic act, input logic [7:0] idx, input logic [7:0] lanes,
                           input logic [7:0] g, input logic [7:0] r, input logic [7:0] b,
                           output lane_result_t res);
    int unsigned dbits;
    int unsigned flen;
    int unsigned bp;
    int unsigned p;
    int unsigned base;
    logic        tx;
    dbits = data_len();
    bp    = bit_pos;
    p     = phase;
    tx    = bp < dbits;
    if (act == ACT_WRITE) begin
      if (idx < MAX_LEDS) begin
        base = idx * SLOTS_PER_LED;
        store_colour(base, g, lanes);
        store_colour(base + 8, r, lanes);
        store_colour(base + 16, b, lanes);
      end
    end else begin
      flen = (frame_r > dbits) ? frame_r : dbits;
      if (tx) begin
        // coinciding phases resolve toward low
        if (p == 0) levels = enable_r & LANE_MASK;
        if (p == zero_at_r) levels = levels & ~slot_mask[bp];
        if (p == one_at_r) levels = '0;
        levels = levels & LANE_MASK;
      end else begin
        levels = '0;
      end
      if (p + 1 >= period_r) begin
        phase   = '0;
        bit_pos = (bp + 1 >= flen) ? 16'd0 : 16'(bp + 1);
      end else begin
        phase = 8'(p + 1);
      end
    end
    res.lines          = levels;
    res.transmitting   = tx;
    res.frame_position = 16'(bp);
  endtask

  always @(posedge clk) begin
    lane_result_t want;
    if (!rst_n) begin
      clear_model();
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with no item waiting: lines %02h", out_lines));
        end else begin
          want = expected_results.pop_front();
          if (out_lines !== want.lines)
            report_mismatch($sformatf("lines %02h, want %02h", out_lines, want.lines));
          if (out_transmitting !== want.transmitting)
            report_mismatch($sformatf("transmitting %0b, want %0b",
                                      out_transmitting, want.transmitting));
          if (out_frame_position !== want.frame_position)
            report_mismatch($sformatf("frame_position %0d, want %0d",
                                      out_frame_position, want.frame_position));
        end
      end
      if (in_valid && in_ready) begin
        step_item(in_action, in_led_index, in_lane_select, in_green, in_red, in_blue, want);
        expected_results.push_back(want);
      end
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
    end
    queued_n <= expected_results.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the multi-lane LED chain bit encoder: pixel writes and timer
// ticks under a series of register settings, random idling on both sides,
// a cycle watchdog and the final verdict. Checking is done by the checker.
// ----------------------------------------------------------------------------
module tb;
  import mlle_pkg::*;
  import lane_tb_pkg::*;

  localparam int IDLE_LIMIT = 4000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_action;
  logic [7:0]            in_led_index;
  logic [7:0]            in_lane_select;
  logic [7:0]            in_green;
  logic [7:0]            in_red;
  logic [7:0]            in_blue;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            out_lines;
  logic                  out_transmitting;
  logic [15:0]           out_frame_position;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_total;
  int in_flight;
  int stall_cycles = 0;
  int led_hi = 0;
  bit calm = 1'b0;

  multi_lane_led_chain_bit_encoder_unit u_top (.*);

  lane_waveform_checker u_checker (
    .*,
    .errors      (fail_total),
    .outstanding (in_flight)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) out_ready <= calm || ($urandom_range(0, 99) >= 24);

  // end the run when no channel moves an item for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= IDLE_LIMIT) begin
      $display("FAIL multi_lane_led_chain_bit_encoder_unit");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_item(input logic act, input logic [7:0] idx, input logic [7:0] lanes,
                           input logic [7:0] g, input logic [7:0] r, input logic [7:0] b);
    if (!calm && $urandom_range(0, 99) < 24) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_led_index   <= idx;
    in_lane_select <= lanes;
    in_green       <= g;
    in_red         <= r;
    in_blue        <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic run_random(input int n, input int tick_pct);
    logic       act;
    logic [7:0] idx;
    for (int i = 0; i < n; i++) begin
      act = ($urandom_range(0, 99) < tick_pct) ? ACT_TICK : ACT_WRITE;
      idx = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, led_hi));
      send_item(act, idx, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  // hold until every result is back, then leave room for the result register
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // upper data bits beyond each register width are random and must be dropped
  task automatic apply_regs(input logic [7:0] period, input logic [7:0] zero_at,
                            input logic [7:0] one_at, input logic [8:0] leds,
                            input logic [15:0] frame, input logic [7:0] enable);
    settle();
    write_reg(REG_PERIOD_TICKS, {8'($urandom), period});
    write_reg(REG_ZERO_HIGH_TICKS, {8'($urandom), zero_at});
    write_reg(REG_ONE_HIGH_TICKS, {8'($urandom), one_at});
    write_reg(REG_LED_COUNT, {7'($urandom), leds});
    write_reg(REG_FRAME_BITS, frame);
    write_reg(REG_LANE_ENABLE, {8'($urandom), enable});
    cfg_valid <= 1'b0;
    led_hi = (leds == 0) ? 0 : ((leds > MAX_LEDS) ? MAX_LEDS - 1 : leds - 1);
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_action      <= ACT_WRITE;
    in_led_index   <= '0;
    in_lane_select <= '0;
    in_green       <= '0;
    in_red         <= '0;
    in_blue        <= '0;
    out_ready      <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, colour and lane extremes, first and last LED
    send_item(ACT_WRITE, 8'd0, 8'hFF, 8'h00, 8'hFF, 8'hA5);
    send_item(ACT_TICK, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(ACT_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_item(ACT_WRITE, 8'd255, 8'h00, 8'hFF, 8'h00, 8'h5A);
    send_item(ACT_WRITE, 8'd1, 8'h5A, 8'h80, 8'h01, 8'h7E);
    send_item(ACT_TICK, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);

    // short period with both low events on the same phase
    apply_regs(8'd2, 8'd1, 8'd1, 9'd1, 16'd30, 8'hA5);
    send_item(ACT_WRITE, 8'd0, 8'hC3, 8'hAA, 8'h55, 8'h0F);
    repeat (8) send_item(ACT_TICK, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);

    // frame shorter than the data: lengthen to fit
    apply_regs(8'd4, 8'd1, 8'd3, 9'd2, 16'd24, 8'hFF);
    send_item(ACT_WRITE, 8'd1, 8'h3C, 8'hF0, 8'h0F, 8'h99);
    run_random(250, 85);

    // one-tick period, no LEDs, empty frame
    apply_regs(8'd0, 8'd0, 8'd0, 9'd0, 16'd0, 8'hFF);
    run_random(60, 80);
    apply_regs(8'd1, 8'd0, 8'd0, 9'd1, 16'd0, 8'hFF);
    run_random(80, 80);

    // low events beyond the period never fire
    apply_regs(8'd6, 8'd8, 8'd9, 9'd1, 16'd26, 8'h3C);
    run_random(150, 85);

    // led count above the store clamps; spare register indexes do nothing
    apply_regs(8'd5, 8'd2, 8'd254, 9'd511, 16'd65535, 8'hFF);
    write_reg(REG_SPARE_A, 16'($urandom));
    write_reg(REG_SPARE_B, 16'($urandom));
    cfg_valid <= 1'b0;
    run_random(100, 60);

    // longest period, full chain, no lanes enabled
    apply_regs(8'd255, 8'd254, 8'd1, 9'd256, 16'd24, 8'h00);
    run_random(150, 95);

    // run with no idling on either side
    apply_regs(8'd3, 8'd1, 8'd2, 9'd3, 16'd80, 8'($urandom));
    calm <= 1'b1;
    run_random(150, 80);
    in_valid <= 1'b0;
    calm     <= 1'b0;

    apply_regs(8'd7, 8'd3, 8'd5, 9'd1, 16'd24, 8'h01);
    run_random(120, 85);

    for (int ph = 0; ph < 4; ph++) begin
      apply_regs(8'($urandom_range(2, 8)), 8'($urandom_range(1, 9)), 8'($urandom_range(1, 9)),
                 9'($urandom_range(0, 3)), 16'($urandom_range(24, 120)), 8'($urandom));
      run_random(50, 80);
    end

    settle();
    repeat (8) @(posedge clk);
    if (fail_total == 0 && in_flight == 0) begin
      $display("PASS multi_lane_led_chain_bit_encoder_unit");
    end else begin
      $display("FAIL multi_lane_led_chain_bit_encoder_unit");
    end
    $finish;
  end

endmodule
